// ===== rtl/plht_pkg.sv =====
// ----------------------------------------------------------------------------
// plht_pkg
// Shared types and constants for the polyline hit-test store.
// ----------------------------------------------------------------------------
package plht_pkg;

  localparam int IN_COORD_BITS = 16;
  localparam int RAD_BITS      = 15;
  localparam int RAD_SQ_BITS   = 2 * RAD_BITS;
  localparam int COUNT_BITS    = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_MOVE  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

// ===== rtl/polyline_hit_test_store_top.sv =====
// ----------------------------------------------------------------------------
// polyline_hit_test_store_top
// Vertex store with push, pop, move-all and point-near-polyline query.
// ----------------------------------------------------------------------------
// Move and query walk the vertex memory one entry per cycle through its single
// read port; a query feeds each segment into a test pipeline (line equation,
// products, squared distance against r^2(a^2+b^2)), and a move writes each
// entry back in the cycle after reading it. One request is in work at a time;
// the result register holds a finished result while the next request is taken.
module polyline_hit_test_store_top #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  plht_pkg::op_t                          in_operation,
  input  logic signed [plht_pkg::IN_COORD_BITS-1:0] in_x_coord,
  input  logic signed [plht_pkg::IN_COORD_BITS-1:0] in_y_coord,
  input  logic [plht_pkg::RAD_BITS-1:0]          in_radius,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic [plht_pkg::COUNT_BITS-1:0]        out_vertex_count,
  output logic [1:0]                             out_status
);

  import plht_pkg::*;

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CNW = $clog2(MAX_VERTICES + 1);
  localparam int C   = COORD_BITS;
  localparam int EW  = ((C > IN_COORD_BITS) ? C : IN_COORD_BITS) + 1;
  localparam int DW  = 2 * EW + 1;
  localparam int H   = EW + 1;
  localparam int CW  = 2 * DW;
  localparam int RSW = RAD_SQ_BITS + DW;
  localparam logic signed [EW-1:0] CMAX = EW'((2 ** (C - 1)) - 1);
  localparam logic signed [EW-1:0] CMIN = -CMAX - EW'(1);

  function automatic logic [C-1:0] sat_coord(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] t;
    begin
      t = v;
      if (v > CMAX) t = CMAX;
      if (v < CMIN) t = CMIN;
      sat_coord = t[C-1:0];
    end
  endfunction

  // control
  state_t               state_r, state_nxt;
  logic [CNW-1:0]       count_r, count_nxt;
  logic [AW-1:0]        idx_r;
  op_t                  op_r;
  logic signed [IN_COORD_BITS-1:0] qx_r, qy_r;
  logic [RAD_SQ_BITS-1:0] r2_r;
  status_t              status_r;
  logic                 hit_r;
  logic                 out_valid_r, out_hit_r;
  logic [COUNT_BITS-1:0] out_count_r;
  status_t              out_status_r;

  logic                 in_acc, walk_last, pipe_busy, out_free, load_out;
  logic                 push_ok, pop_ok;
  logic [CNW+COUNT_BITS-1:0] count_ext;

  // memory
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*C-1:0]       ram_wdata, ram_rdata;

  // read return
  logic                 rv_r;
  logic [AW-1:0]        ri_r;
  logic [C-1:0]         prev_x_r, prev_y_r;

  assign in_acc    = in_valid && !in_stall;
  assign push_ok   = (count_r != CNW'(MAX_VERTICES));
  assign pop_ok    = (count_r != '0);
  assign walk_last = ({{(CNW-AW){1'b0}}, idx_r} == count_r - CNW'(1));
  assign out_free  = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_operation)
            OP_PUSH, OP_POP: state_nxt = S_DONE;
            OP_MOVE:  state_nxt = (count_r == '0) ? S_DONE : S_WALK;
            OP_QUERY: state_nxt = (count_r < CNW'(2)) ? S_DONE : S_WALK;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK:  if (walk_last) state_nxt = S_DRAIN;
      S_DRAIN: if (!pipe_busy) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_stall  = 1'b1;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_WALK:  in_stall = 1'b1;
      S_DRAIN: in_stall = 1'b1;
      S_DONE:  load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc && in_operation == OP_PUSH && push_ok) count_nxt = count_r + CNW'(1);
    if (in_acc && in_operation == OP_POP && pop_ok)   count_nxt = count_r - CNW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rv_r    <= (state_r == S_WALK);
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ri_r <= idx_r;
    if (in_acc) begin
      op_r  <= in_operation;
      qx_r  <= in_x_coord;
      qy_r  <= in_y_coord;
      r2_r  <= RAD_SQ_BITS'(in_radius) * RAD_SQ_BITS'(in_radius);
      idx_r <= '0;
      priority if (in_operation == OP_PUSH && !push_ok) status_r <= STAT_FULL;
      else if (in_operation == OP_POP && !pop_ok)       status_r <= STAT_EMPTY;
      else                                              status_r <= STAT_OK;
    end else if (state_r == S_WALK) begin
      idx_r <= idx_r + AW'(1);
    end
    if (rv_r) begin
      prev_x_r <= ram_rdata[2*C-1:C];
      prev_y_r <= ram_rdata[C-1:0];
    end
    if (load_out) begin
      out_hit_r    <= hit_r && (op_r == OP_QUERY);
      out_count_r  <= count_ext[COUNT_BITS-1:0];
      out_status_r <= status_r;
    end
  end

  assign count_ext = {{COUNT_BITS{1'b0}}, count_r};

  // write port: push at request, move writes back the entry read in the previous cycle
  logic signed [EW-1:0] mv_x, mv_y, psh_x, psh_y;
  assign mv_x  = EW'(signed'(ram_rdata[2*C-1:C])) + EW'(qx_r);
  assign mv_y  = EW'(signed'(ram_rdata[C-1:0]))   + EW'(qy_r);
  assign psh_x = EW'(in_x_coord);
  assign psh_y = EW'(in_y_coord);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = {sat_coord(psh_x), sat_coord(psh_y)};
    if (in_acc && in_operation == OP_PUSH && push_ok) begin
      ram_we = 1'b1;
    end else if (rv_r && op_r == OP_MOVE) begin
      ram_we    = 1'b1;
      ram_waddr = ri_r;
      ram_wdata = {sat_coord(mv_x), sat_coord(mv_y)};
    end
  end

  plht_ram #(
    .WIDTH (2 * C),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // segment test pipeline
  logic signed [EW-1:0] x0, y0, x1, y1, qx_e, qy_e, sa, sb, sdx, sdy;
  logic                 span_ok, seg_ok;
  assign x0   = EW'(signed'(prev_x_r));
  assign y0   = EW'(signed'(prev_y_r));
  assign x1   = EW'(signed'(ram_rdata[2*C-1:C]));
  assign y1   = EW'(signed'(ram_rdata[C-1:0]));
  assign qx_e = EW'(qx_r);
  assign qy_e = EW'(qy_r);
  assign sa   = y1 - y0;
  assign sb   = x0 - x1;
  assign sdx  = qx_e - x0;
  assign sdy  = qy_e - y0;

  always_comb begin
    if (sb == '0) begin
      span_ok = (qy_e >= ((y0 < y1) ? y0 : y1)) && (qy_e <= ((y0 < y1) ? y1 : y0));
    end else begin
      span_ok = (qx_e >= ((x0 < x1) ? x0 : x1)) && (qx_e <= ((x0 < x1) ? x1 : x0));
    end
  end

  // skip the first vertex and zero-length segments
  assign seg_ok = rv_r && (op_r == OP_QUERY) && (ri_r != '0) &&
                  !(sa == '0 && sb == '0) && span_ok;

  logic                   va_r, vb_r, vc_r, vd_r, ve_r;
  logic signed [EW-1:0]   a_r, b_r, dx_r, dy_r;
  logic signed [2*EW-1:0] p1_r, p2_r;
  logic [2*EW-1:0]        aa_r, bb_r;
  logic [EW-1:0]          am, bm;
  logic signed [DW-1:0]   dsum;
  logic [DW-1:0]          dm_r, s_r;
  logic [2*H-1:0]         ll_r;
  logic [H+EW-1:0]        lh_r;
  logic [2*EW-1:0]        hh_r;
  logic [RAD_SQ_BITS+H-1:0]  rl_r;
  logic [RAD_SQ_BITS+EW-1:0] rh_r;
  logic [CW-1:0]          d2_r;
  logic [RSW-1:0]         rs_r;

  assign am   = a_r[EW-1] ? EW'(-a_r) : EW'(a_r);
  assign bm   = b_r[EW-1] ? EW'(-b_r) : EW'(b_r);
  assign dsum = DW'(p1_r) + DW'(p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= seg_ok;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= sa;
    b_r  <= sb;
    dx_r <= sdx;
    dy_r <= sdy;
    p1_r <= a_r * dx_r;
    p2_r <= b_r * dy_r;
    aa_r <= am * am;
    bb_r <= bm * bm;
    dm_r <= dsum[DW-1] ? DW'(-dsum) : DW'(dsum);
    s_r  <= DW'(aa_r) + DW'(bb_r);
    ll_r <= dm_r[H-1:0] * dm_r[H-1:0];
    lh_r <= dm_r[H-1:0] * dm_r[DW-1:H];
    hh_r <= dm_r[DW-1:H] * dm_r[DW-1:H];
    rl_r <= r2_r * s_r[H-1:0];
    rh_r <= r2_r * s_r[DW-1:H];
    d2_r <= CW'(ll_r) + (CW'(lh_r) << (H + 1)) + (CW'(hh_r) << (2 * H));
    rs_r <= RSW'(rl_r) + (RSW'(rh_r) << H);
    if (in_acc) begin
      hit_r <= 1'b0;
    end else if (ve_r && (d2_r <= CW'(rs_r))) begin
      hit_r <= 1'b1;
    end
  end

  assign pipe_busy = rv_r || va_r || vb_r || vc_r || vd_r || ve_r;

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_vertex_count = out_count_r;
  assign out_status       = out_status_r;

  // checks
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("request taken while busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_PUSH && push_ok) |=> count_r == $past(count_r) + CNW'(1))
    else $error("push did not advance count");

endmodule

// ===== rtl/plht_ram.sv =====
// ----------------------------------------------------------------------------
// plht_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
